// ===== rtl/bpsp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the bmp pixel stream parser
// no dependencies; imported by the front, queue, back and top level
package bpsp_pkg;

   localparam int HEADER_BYTES   = 54;
   // only the first 34 header bytes carry fields that are checked or used
   localparam int HDR_KEPT       = 34;
   localparam int COORD_W        = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   localparam int OFS_SIG    = 0;
   localparam int OFS_OFFSET = 10;
   localparam int OFS_INFO   = 14;
   localparam int OFS_WIDTH  = 18;
   localparam int OFS_HEIGHT = 22;
   localparam int OFS_DEPTH  = 28;
   localparam int OFS_COMP   = 30;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [31:0] INFO_SIZE     = 32'd40;
   localparam logic [15:0] PIXEL_DEPTH   = 16'd24;

   // window register indexes on the csr port
   localparam logic [1:0] REG_WIN_X = 2'd0;
   localparam logic [1:0] REG_WIN_Y = 2'd1;
   localparam logic [1:0] REG_WIN_W = 2'd2;
   localparam logic [1:0] REG_WIN_H = 2'd3;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_SIGNATURE  = 3'd0,
      ERR_INFO_SIZE  = 3'd1,
      ERR_DEPTH      = 3'd2,
      ERR_COMPRESSED = 3'd3,
      ERR_SIZE_RANGE = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      OP_BYTE   = 2'd0,
      OP_SETUP  = 2'd1,
      OP_RESULT = 2'd2
   } op_type;

   // one queue entry: a pixel data byte, an image setup or a finished result
   typedef struct packed {
      op_type      op;
      kind_type    kind;
      err_type     code;
      logic [7:0]  data;
      logic [15:0] eff_width;
      logic [15:0] rows;
      logic [15:0] cur_y;
      logic [17:0] row_bytes;
      logic        bottom_up;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/bpsp_front.sv =====
`timescale 1ns / 1ps
// front end: takes file bytes, gathers and checks the header, skips to the
// pixel data and forwards work entries; depends on bpsp_pkg
module bpsp_front import bpsp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        command,
   input  logic [7:0]  data_byte,
   input  logic [15:0] win_y,
   input  logic [15:0] win_w,
   input  logic [15:0] win_h,
   output logic        push,
   output entry_type   entry
);

   localparam int CNT_W = $clog2(HEADER_BYTES);

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_HEADER,
      FR_SKIP,
      FR_PIXELS
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [CNT_W-1:0]        hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]             skip_ff, skip_in;
   logic [8*HDR_KEPT-1:0]   hdr_sr_ff;

   logic [15:0] f_sig;
   logic [31:0] f_offset;
   logic [31:0] f_info;
   logic [31:0] f_width;
   logic [31:0] f_height;
   logic [15:0] f_depth;
   logic [31:0] f_comp;
   logic [31:0] hmag;
   logic        hdr_bad;
   err_type     hdr_code;
   logic [15:0] eff_w;
   logic [15:0] eff_h;
   logic [17:0] row_bytes;
   logic        bottom_up;
   logic [15:0] y_base;
   logic [31:0] skip_new;
   logic        hdr_last;
   logic        sr_shift;

   // bytes shift in from the top, so byte k ends at bits 8k
   assign f_sig    = hdr_sr_ff[8*OFS_SIG    +: 16];
   assign f_offset = hdr_sr_ff[8*OFS_OFFSET +: 32];
   assign f_info   = hdr_sr_ff[8*OFS_INFO   +: 32];
   assign f_width  = hdr_sr_ff[8*OFS_WIDTH  +: 32];
   assign f_height = hdr_sr_ff[8*OFS_HEIGHT +: 32];
   assign f_depth  = hdr_sr_ff[8*OFS_DEPTH  +: 16];
   assign f_comp   = hdr_sr_ff[8*OFS_COMP   +: 32];

   assign hmag = f_height[31] ? (32'd0 - f_height) : f_height;

   always_comb begin
      hdr_bad  = 1'b1;
      hdr_code = ERR_SIGNATURE;
      if (f_sig != BMP_SIGNATURE) begin
         hdr_code = ERR_SIGNATURE;
      end else if (f_info != INFO_SIZE) begin
         hdr_code = ERR_INFO_SIZE;
      end else if (f_depth != PIXEL_DEPTH) begin
         hdr_code = ERR_DEPTH;
      end else if (f_comp != 32'd0) begin
         hdr_code = ERR_COMPRESSED;
      end else if (f_width[31:16] != 16'd0 || hmag[31:16] != 16'd0) begin
         hdr_code = ERR_SIZE_RANGE;
      end else begin
         hdr_bad = 1'b0;
      end
   end

   assign eff_w     = (win_w < f_width[15:0]) ? win_w : f_width[15:0];
   assign eff_h     = (win_h < hmag[15:0]) ? win_h : hmag[15:0];
   // three bytes per pixel, rounded up to a multiple of four
   assign row_bytes = ({2'b00, f_width[15:0]} + {1'b0, f_width[15:0], 1'b0} + 18'd3)
                      & ~18'd3;
   assign bottom_up = (f_height != 32'd0) && !f_height[31];
   assign y_base    = bottom_up ? (win_y + eff_h - 16'd1) : win_y;
   assign skip_new  = (f_offset > 32'(HEADER_BYTES)) ? (f_offset - 32'(HEADER_BYTES))
                                                     : 32'd0;
   assign hdr_last  = (hdr_cnt_ff == CNT_W'(HEADER_BYTES - 1));
   assign sr_shift  = accept && !command && (phase_ff == FR_HEADER)
                      && (hdr_cnt_ff < CNT_W'(HDR_KEPT));

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      skip_in    = skip_ff;
      push       = 1'b0;
      entry      = '0;
      entry.op   = OP_BYTE;
      entry.data = data_byte;
      if (accept) begin
         if (command) begin
            phase_in   = FR_HEADER;
            hdr_cnt_in = '0;
         end else begin
            case (phase_ff)
               FR_HEADER: begin
                  if (!hdr_last) begin
                     hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  end else begin
                     hdr_cnt_in = '0;
                     push       = 1'b1;
                     if (hdr_bad) begin
                        entry.op   = OP_RESULT;
                        entry.kind = KIND_ERROR;
                        entry.code = hdr_code;
                        phase_in   = FR_IDLE;
                     end else if (eff_h == 16'd0 || f_width[15:0] == 16'd0) begin
                        // empty image finishes on the last header byte
                        entry.op   = OP_RESULT;
                        entry.kind = KIND_DONE;
                        phase_in   = FR_IDLE;
                     end else begin
                        entry.op        = OP_SETUP;
                        entry.eff_width = eff_w;
                        entry.rows      = eff_h;
                        entry.cur_y     = COORD_W'(y_base[COORD_BITS-1:0]);
                        entry.row_bytes = row_bytes;
                        entry.bottom_up = bottom_up;
                        skip_in         = skip_new;
                        phase_in        = (skip_new != 32'd0) ? FR_SKIP : FR_PIXELS;
                     end
                  end
               end
               FR_SKIP: begin
                  skip_in = skip_ff - 32'd1;
                  if (skip_ff == 32'd1) begin
                     phase_in = FR_PIXELS;
                  end
               end
               FR_PIXELS: begin
                  push = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= FR_IDLE;
         hdr_cnt_ff <= '0;
         skip_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         skip_ff    <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sr_shift) begin
         hdr_sr_ff <= {data_byte, hdr_sr_ff[8*HDR_KEPT-1:8]};
      end
   end

endmodule

// ===== rtl/bpsp_queue.sv =====
`timescale 1ns / 1ps
// short entry queue between front and back end
// depends on bpsp_pkg for the entry and status types
module bpsp_queue import bpsp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/bpsp_back.sv =====
`timescale 1ns / 1ps
// back end: walks pixel rows, pairs bgr triples into rgb pixels and holds
// the result register; depends on bpsp_pkg
module bpsp_back import bpsp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  entry_type          q_entry,
   output logic               q_pop,
   input  logic [15:0]        win_x,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_error_code,
   output logic [COORD_W-1:0] rsp_px_x,
   output logic [COORD_W-1:0] rsp_px_y,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   localparam logic [1:0] COMP_BLUE  = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_RED   = 2'd2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PIXELS,
      BK_PENDING
   } state_type;

   state_type             state_ff, state_in;
   logic [17:0]           row_cnt_ff, row_cnt_in;
   logic [17:0]           rb_last_ff, rb_last_in;
   logic [1:0]            comp_ff, comp_in;
   logic [15:0]           idx_ff, idx_in;
   logic [15:0]           eff_w_ff, eff_w_in;
   logic [15:0]           rows_ff, rows_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic                  up_ff, up_in;
   logic [7:0]            blue_ff, blue_in;
   logic [7:0]            green_ff, green_in;

   logic                  valid_ff, valid_in;
   kind_type              kind_ff, kind_in;
   err_type               code_ff, code_in;
   logic [COORD_W-1:0]    x_out_ff, x_out_in;
   logic [COORD_W-1:0]    y_out_ff, y_out_in;
   logic [7:0]            r_out_ff, r_out_in;
   logic [7:0]            g_out_ff, g_out_in;
   logic [7:0]            b_out_ff, b_out_in;

   logic                  go;
   logic                  in_win;
   logic                  pix;
   logic                  row_end;
   logic [COORD_BITS-1:0] x_pix;

   assign go      = q_valid && (!valid_ff || rsp_ready);
   assign q_pop   = go;
   assign in_win  = idx_ff < eff_w_ff;
   assign pix     = in_win && (comp_ff == COMP_RED);
   assign row_end = (row_cnt_ff == rb_last_ff);
   assign x_pix   = win_x[COORD_BITS-1:0] + idx_ff[COORD_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      row_cnt_in = row_cnt_ff;
      rb_last_in = rb_last_ff;
      comp_in    = comp_ff;
      idx_in     = idx_ff;
      eff_w_in   = eff_w_ff;
      rows_in    = rows_ff;
      y_in       = y_ff;
      up_in      = up_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      valid_in   = valid_ff && !rsp_ready;
      kind_in    = kind_ff;
      code_in    = code_ff;
      x_out_in   = x_out_ff;
      y_out_in   = y_out_ff;
      r_out_in   = r_out_ff;
      g_out_in   = g_out_ff;
      b_out_in   = b_out_ff;
      if (go) begin
         case (q_entry.op)
            OP_RESULT: begin
               valid_in = 1'b1;
               kind_in  = q_entry.kind;
               code_in  = q_entry.code;
               x_out_in = '0;
               y_out_in = '0;
               r_out_in = '0;
               g_out_in = '0;
               b_out_in = '0;
               state_in = BK_IDLE;
            end
            OP_SETUP: begin
               row_cnt_in = '0;
               rb_last_in = q_entry.row_bytes - 18'd1;
               comp_in    = COMP_BLUE;
               idx_in     = '0;
               eff_w_in   = q_entry.eff_width;
               rows_in    = q_entry.rows;
               y_in       = q_entry.cur_y[COORD_BITS-1:0];
               up_in      = q_entry.bottom_up;
               state_in   = BK_PIXELS;
            end
            OP_BYTE: begin
               case (state_ff)
                  BK_PENDING: begin
                     // the beat after the pixel that ends the last row carries the done result
                     valid_in = 1'b1;
                     kind_in  = KIND_DONE;
                     code_in  = ERR_SIGNATURE;
                     x_out_in = '0;
                     y_out_in = '0;
                     r_out_in = '0;
                     g_out_in = '0;
                     b_out_in = '0;
                     state_in = BK_IDLE;
                  end
                  BK_PIXELS: begin
                     if (in_win && comp_ff == COMP_BLUE) begin
                        blue_in = q_entry.data;
                     end
                     if (in_win && comp_ff == COMP_GREEN) begin
                        green_in = q_entry.data;
                     end
                     if (pix) begin
                        valid_in = 1'b1;
                        kind_in  = KIND_PIXEL;
                        code_in  = ERR_SIGNATURE;
                        x_out_in = COORD_W'(x_pix);
                        y_out_in = COORD_W'(y_ff);
                        r_out_in = q_entry.data;
                        g_out_in = green_ff;
                        b_out_in = blue_ff;
                     end
                     if (row_end) begin
                        row_cnt_in = '0;
                        comp_in    = COMP_BLUE;
                        idx_in     = '0;
                        rows_in    = rows_ff - 16'd1;
                        y_in       = up_ff ? (y_ff - 1'b1) : (y_ff + 1'b1);
                        if (rows_ff == 16'd1) begin
                           if (pix) begin
                              state_in = BK_PENDING;
                           end else begin
                              valid_in = 1'b1;
                              kind_in  = KIND_DONE;
                              code_in  = ERR_SIGNATURE;
                              x_out_in = '0;
                              y_out_in = '0;
                              r_out_in = '0;
                              g_out_in = '0;
                              b_out_in = '0;
                              state_in = BK_IDLE;
                           end
                        end
                     end else begin
                        row_cnt_in = row_cnt_ff + 18'd1;
                        if (comp_ff == COMP_RED) begin
                           comp_in = COMP_BLUE;
                           idx_in  = idx_ff + 16'd1;
                        end else begin
                           comp_in = comp_ff + 2'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      row_cnt_ff <= row_cnt_in;
      rb_last_ff <= rb_last_in;
      comp_ff    <= comp_in;
      idx_ff     <= idx_in;
      eff_w_ff   <= eff_w_in;
      rows_ff    <= rows_in;
      y_ff       <= y_in;
      up_ff      <= up_in;
      blue_ff    <= blue_in;
      green_ff   <= green_in;
      kind_ff    <= kind_in;
      code_ff    <= code_in;
      x_out_ff   <= x_out_in;
      y_out_ff   <= y_out_in;
      r_out_ff   <= r_out_in;
      g_out_ff   <= g_out_in;
      b_out_ff   <= b_out_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_error_code = code_ff;
   assign rsp_px_x       = x_out_ff;
   assign rsp_px_y       = y_out_ff;
   assign rsp_red        = r_out_ff;
   assign rsp_green      = g_out_ff;
   assign rsp_blue       = b_out_ff;

endmodule

// ===== rtl/bmp_pixel_stream_parser.sv =====
`timescale 1ns / 1ps
// top level of the bmp pixel stream parser: window registers on the csr port,
// front end, entry queue and back end; depends on bpsp_pkg and the bpsp_ modules
//
// usage: a start beat (req_command = 1) opens an image, then every file byte
// goes in as one data beat (req_command = 0). the 54-byte header is checked
// (signature, info size, 24-bit depth, no compression, size range); a failure
// gives one error result. pixel beats give one rgb pixel result per file
// triple inside the window, then one done result after the last row.
// window registers win_x, win_y, win_w, win_h sit at byte addresses 0, 4, 8
// and 12 and are read when the header completes (win_x as pixels go out).
// throughput is one beat per cycle while the receiver keeps up: the front end
// handles every beat in the cycle it is accepted, and the back end retires
// one queue entry per cycle while its result register is free or being taken.
// an accepted beat is registered in the entry queue, then in the result register.
// when the receiver stalls, the result register holds, the back end stops
// and the four-entry queue absorbs beats until req_ready drops.
// reset clears the window registers, the queue, the front end state and the
// back end state and valid flag; the block takes beats with no clearing pass.
module bmp_pixel_stream_parser import bpsp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int Q_DEPTH    = QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_error_code,
   output logic [COORD_W-1:0] rsp_px_x,
   output logic [COORD_W-1:0] rsp_px_y,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [15:0]  win_x_ff, win_y_ff, win_w_ff, win_h_ff;
   logic         csr_wr;
   logic         accept;
   logic         q_push;
   logic         q_pop;
   entry_type    q_in_entry;
   entry_type    q_head;
   q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff <= '0;
         win_y_ff <= '0;
         win_w_ff <= '0;
         win_h_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_WIN_X: win_x_ff <= csr_pwdata[15:0];
            REG_WIN_Y: win_y_ff <= csr_pwdata[15:0];
            REG_WIN_W: win_w_ff <= csr_pwdata[15:0];
            REG_WIN_H: win_h_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIN_X: csr_prdata = {16'd0, win_x_ff};
         REG_WIN_Y: csr_prdata = {16'd0, win_y_ff};
         REG_WIN_W: csr_prdata = {16'd0, win_w_ff};
         REG_WIN_H: csr_prdata = {16'd0, win_h_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   bpsp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .data_byte (req_data_byte),
      .win_y     (win_y_ff),
      .win_w     (win_w_ff),
      .win_h     (win_h_ff),
      .push      (q_push),
      .entry     (q_in_entry)
   );

   bpsp_queue #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   bpsp_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (!q_status.empty),
      .q_entry        (q_head),
      .q_pop          (q_pop),
      .win_x          (win_x_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_px_x       (rsp_px_x),
      .rsp_px_y       (rsp_px_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

`ifndef SYNTHESIS
   a_reset_no_result: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_pixel_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PIXEL) |-> (rsp_error_code == ERR_SIGNATURE))
      else $error("pixel result with nonzero error code");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");
`endif

endmodule

// ===== verif/tb_bmp_pixel_stream_parser.sv =====
`timescale 1ns / 1ps
// self-checking testbench of bmp_pixel_stream_parser: byte-level decoder model,
// directed bmp files followed by random well-formed and broken files
// depends on bpsp_pkg and the rtl of bmp_pixel_stream_parser
module tb_bmp_pixel_stream_parser;
   import bpsp_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int IDLE_PCT      = 23;
   localparam int RANDOM_BEATS  = 150;
   localparam int STEADY_BEATS  = 50;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 120;
   localparam int STALL_LIMIT   = 2000;

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // error code reads zero outside error results
   localparam err_type NO_ERROR = ERR_SIGNATURE;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_SKIP,
      ST_PIXELS,
      ST_PENDING
   } parse_state_type;

   typedef struct packed {
      kind_type    kind;
      err_type     code;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } decoded_type;

   typedef struct packed {
      logic [15:0] sig;
      logic [31:0] info;
      logic [15:0] depth;
      logic [31:0] comp;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] offset;
   } bmp_header_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_data_byte = 8'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_px_x;
   logic [15:0] rsp_px_y;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // decoder model state
   parse_state_type parse_st = ST_IDLE;
   int           hdr_count = 0;
   logic [7:0]   seen_hdr [HEADER_BYTES];
   logic [31:0]  skip_left = 32'h0;
   logic [31:0]  row_pos = 32'h0;
   logic [31:0]  row_len = 32'h0;
   logic [15:0]  rows_todo = 16'h0;
   logic [15:0]  y_now = 16'h0;
   logic [15:0]  span = 16'h0;
   bit           upward = 1'b0;
   logic [7:0]   hold_b = 8'h0;
   logic [7:0]   hold_g = 8'h0;
   logic [15:0]  win_reg [4];

   decoded_type due_results [$];
   logic [7:0]  file_hdr [HEADER_BYTES];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          stall_cycles = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   bit          steady = 1'b0;

   bmp_pixel_stream_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_px_x       (rsp_px_x),
      .rsp_px_y       (rsp_px_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic [31:0] le16(input int at);
      return {16'h0, seen_hdr[at + 1], seen_hdr[at]};
   endfunction

   function automatic logic [31:0] le32(input int at);
      return {seen_hdr[at + 3], seen_hdr[at + 2], seen_hdr[at + 1], seen_hdr[at]};
   endfunction

   function automatic void expect_result(input kind_type k, input err_type c,
                                         input logic [15:0] x, input logic [15:0] y,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] bl);
      decoded_type d;
      d.kind  = k;
      d.code  = c;
      d.x     = x;
      d.y     = y;
      d.red   = r;
      d.green = g;
      d.blue  = bl;
      due_results.push_back(d);
   endfunction

   // advances the decoder model by one accepted beat
   function automatic void decode_beat(input logic cmd, input logic [7:0] b);
      logic [31:0] width, height, hmag, rows_kept, pos, pix_idx;
      err_type     code;
      bit          header_bad, gave_pixel;
      if (cmd == CMD_START) begin
         parse_st  = ST_HEADER;
         hdr_count = 0;
         return;
      end
      case (parse_st)
         ST_HEADER: begin
            seen_hdr[hdr_count] = b;
            hdr_count++;
            if (hdr_count == HEADER_BYTES) begin
               hdr_count  = 0;
               width      = le32(OFS_WIDTH);
               height     = le32(OFS_HEIGHT);
               hmag       = height[31] ? -height : height;
               header_bad = 1'b1;
               code       = ERR_SIGNATURE;
               if (le16(OFS_SIG) != BMP_SIGNATURE) code = ERR_SIGNATURE;
               else if (le32(OFS_INFO) != INFO_SIZE) code = ERR_INFO_SIZE;
               else if (le16(OFS_DEPTH) != PIXEL_DEPTH) code = ERR_DEPTH;
               else if (le32(OFS_COMP) != 32'h0) code = ERR_COMPRESSED;
               else if (width > 32'hFFFF || hmag > 32'hFFFF) code = ERR_SIZE_RANGE;
               else header_bad = 1'b0;
               if (header_bad) begin
                  parse_st = ST_IDLE;
                  expect_result(KIND_ERROR, code, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0);
               end else begin
                  span = (win_reg[REG_WIN_W] < width) ? win_reg[REG_WIN_W] : width[15:0];
                  rows_kept = (win_reg[REG_WIN_H] < hmag) ? win_reg[REG_WIN_H] : hmag;
                  row_len = 3 * width;
                  if (row_len[1:0] != 2'd0) row_len = row_len + 4 - row_len[1:0];
                  upward = (height != 32'h0) && !height[31];
                  y_now = upward ? win_reg[REG_WIN_Y] + rows_kept[15:0] - 16'd1
                                 : win_reg[REG_WIN_Y];
                  rows_todo = rows_kept[15:0];
                  row_pos = 32'h0;
                  skip_left = (le32(OFS_OFFSET) > HEADER_BYTES) ?
                              le32(OFS_OFFSET) - HEADER_BYTES : 32'h0;
                  if (rows_kept == 32'h0 || row_len == 32'h0) begin
                     parse_st = ST_IDLE;
                     expect_result(KIND_DONE, NO_ERROR, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0);
                  end else begin
                     parse_st = (skip_left != 32'h0) ? ST_SKIP : ST_PIXELS;
                  end
               end
            end
         end
         ST_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 32'h0) parse_st = ST_PIXELS;
         end
         ST_PIXELS: begin
            pos        = row_pos;
            pix_idx    = pos / 3;
            gave_pixel = 1'b0;
            if (pix_idx < {16'h0, span}) begin
               case (pos % 3)
                  0: hold_b = b;
                  1: hold_g = b;
                  default: begin
                     expect_result(KIND_PIXEL, NO_ERROR, win_reg[REG_WIN_X] + pix_idx[15:0],
                                   y_now, b, hold_g, hold_b);
                     gave_pixel = 1'b1;
                  end
               endcase
            end
            if (pos + 1 >= row_len) begin
               row_pos   = 32'h0;
               rows_todo = rows_todo - 16'd1;
               y_now     = upward ? y_now - 16'd1 : y_now + 16'd1;
               if (rows_todo == 16'h0) begin
                  // a pixel on the closing byte pushes done out to the next byte
                  if (gave_pixel) begin
                     parse_st = ST_PENDING;
                  end else begin
                     parse_st = ST_IDLE;
                     expect_result(KIND_DONE, NO_ERROR, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0);
                  end
               end
            end else begin
               row_pos = pos + 1;
            end
         end
         ST_PENDING: begin
            parse_st = ST_IDLE;
            expect_result(KIND_DONE, NO_ERROR, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic send_beat(input logic cmd, input logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      decode_beat(cmd, b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [1:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      win_reg[idx] = value;
   endtask

   task automatic set_window(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] w, input logic [15:0] h);
      drain();
      write_window(REG_WIN_X, x);
      write_window(REG_WIN_Y, y);
      write_window(REG_WIN_W, w);
      write_window(REG_WIN_H, h);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic void put_le(input int at, input logic [31:0] v, input int n);
      for (int k = 0; k < n; k++) file_hdr[at + k] = v[8 * k +: 8];
   endfunction

   function automatic bmp_header_type good_header(input logic [31:0] w,
                                                  input logic [31:0] hgt,
                                                  input logic [31:0] off);
      bmp_header_type h;
      h.sig    = BMP_SIGNATURE;
      h.info   = INFO_SIZE;
      h.depth  = PIXEL_DEPTH;
      h.comp   = 32'h0;
      h.width  = w;
      h.height = hgt;
      h.offset = off;
      return h;
   endfunction

   // skip plus every padded row, for small images only
   function automatic int full_body(input bmp_header_type h);
      logic [31:0] mag, len;
      mag = h.height[31] ? -h.height : h.height;
      len = 3 * h.width;
      if (len[1:0] != 2'd0) len = len + 4 - len[1:0];
      return ((h.offset > HEADER_BYTES) ? h.offset - HEADER_BYTES : 0) + len * mag;
   endfunction

   // spoils exactly one checked field so the expected error code is known
   function automatic bmp_header_type break_header(input bmp_header_type h);
      logic [31:0] mag;
      case ($urandom_range(5))
         0: begin
            h.sig = $urandom;
            if (h.sig == BMP_SIGNATURE) h.sig = ~h.sig;
         end
         1: begin
            h.info = $urandom_range(1) ? 32'd108 : $urandom;
            if (h.info == INFO_SIZE) h.info = ~h.info;
         end
         2: begin
            h.depth = $urandom_range(1) ? 16'd32 : $urandom;
            if (h.depth == PIXEL_DEPTH) h.depth = ~h.depth;
         end
         3: begin
            h.comp = $urandom;
            if (h.comp == 32'h0) h.comp = 32'd1;
         end
         4: h.width = $urandom | 32'h0001_0000;
         default: begin
            mag = ($urandom & 32'h7FFF_FFFF) | 32'h0001_0000;
            h.height = $urandom_range(1) ? mag : -mag;
         end
      endcase
      return h;
   endfunction

   task automatic send_file(input bmp_header_type h, input int body_bytes);
      for (int i = 0; i < HEADER_BYTES; i++) file_hdr[i] = $urandom_range(255);
      put_le(OFS_SIG, {16'h0, h.sig}, 2);
      put_le(OFS_OFFSET, h.offset, 4);
      put_le(OFS_INFO, h.info, 4);
      put_le(OFS_WIDTH, h.width, 4);
      put_le(OFS_HEIGHT, h.height, 4);
      put_le(OFS_DEPTH, {16'h0, h.depth}, 2);
      put_le(OFS_COMP, h.comp, 4);
      send_beat(CMD_START, $urandom_range(255));
      for (int i = 0; i < HEADER_BYTES; i++) send_beat(CMD_DATA, file_hdr[i]);
      repeat (body_bytes) send_beat(CMD_DATA, $urandom_range(255));
   endtask

   function automatic logic [15:0] pick_coord();
      logic [15:0] v;
      case ($urandom_range(3))
         0: v = 16'h0;
         1: v = 16'hFFFF;
         default: v = $urandom_range(65535);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_extent();
      logic [15:0] v;
      case ($urandom_range(3))
         0: v = 16'h0;
         1: v = 16'hFFFF;
         default: v = $urandom_range(8, 1);
      endcase
      return v;
   endfunction

   task automatic test_ignored_before_start();
      send_beat(CMD_DATA, 8'h00);
      send_beat(CMD_DATA, 8'hFF);
      send_beat(CMD_DATA, 8'h5A);
   endtask

   task automatic test_plain_images();
      bmp_header_type h;
      set_window(16'd2, 16'd7, 16'hFFFF, 16'hFFFF);
      // top-down with row padding, trailing bytes after done are dropped
      h = good_header(2, -2, 54);
      send_file(h, full_body(h) + 2);
      h = good_header(3, 2, 62);
      send_file(h, full_body(h));
      // pixel offset inside the header means no skip
      h = good_header(1, 1, 10);
      send_file(h, full_body(h) + 1);
   endtask

   task automatic test_pending_done();
      bmp_header_type h;
      h = good_header(4, -2, 54);
      send_file(h, full_body(h) + 1);
      // the next start throws the held done away
      h = good_header(4, 1, 54);
      send_file(h, full_body(h));
   endtask

   task automatic test_empty_images();
      bmp_header_type h;
      h = good_header(3, 0, 54);
      send_file(h, 2);
      h = good_header(0, 3, 54);
      send_file(h, 2);
      send_file(good_header(32'h0000_FFFF, 0, 54), 1);
      send_file(good_header(0, 32'hFFFF_0001, 54), 1);
   endtask

   task automatic test_aborted_images();
      send_file(good_header(5, 3, 54), 20);
      send_file(good_header(2, 2, 80), 5);
   endtask

   task automatic test_header_errors();
      bmp_header_type base, h;
      base = good_header(2, 2, 54);
      h = base; h.sig = 16'h4D43; send_file(h, 2);
      h = base; h.info = 32'd12; send_file(h, 2);
      h = base; h.depth = 16'd32; send_file(h, 1);
      h = base; h.comp = 32'd1; send_file(h, 1);
      h = base; h.width = 32'h0001_0000; send_file(h, 1);
      h = base; h.width = 32'hFFFF_FFFF; send_file(h, 1);
      h = base; h.height = 32'h8000_0000; send_file(h, 1);
      h = base; h.height = 32'hFFFE_FFFF; send_file(h, 1);
      // several faults at once report the first in check order
      h = base; h.sig = 16'h0; h.info = 32'h0; h.depth = 16'h0; send_file(h, 1);
   endtask

   task automatic test_window_clamp();
      bmp_header_type h;
      set_window(16'hFFFF, 16'hFFFF, 16'd2, 16'd2);
      h = good_header(4, 3, 54);
      send_file(h, full_body(h));
      h = good_header(3, -3, 54);
      send_file(h, full_body(h));
      set_window(16'd0, 16'd0, 16'd0, 16'hFFFF);
      h = good_header(3, 2, 54);
      send_file(h, full_body(h));
      set_window(16'd10, 16'd20, 16'd3, 16'd0);
      h = good_header(3, 2, 54);
      send_file(h, full_body(h));
      set_window(16'd1, 16'd1, 16'hFFFF, 16'd2);
      h = good_header(3, 4, 54);
      send_file(h, full_body(h));
   endtask

   task automatic test_backpressure();
      bmp_header_type h;
      set_window(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      steady = 1'b1;
      hold_requests++;
      h = good_header(6, 4, 54);
      send_file(h, full_body(h) + 1);
      steady = 1'b0;
   endtask

   task automatic test_random_files();
      bmp_header_type h;
      logic [31:0] mag;
      int first, files, pick, body;
      first  = beats_sent;
      files  = 0;
      steady = 1'b1;
      while (beats_sent - first < RANDOM_BEATS) begin
         if (beats_sent - first > STEADY_BEATS) steady = 1'b0;
         if (files % 7 == 6) set_window(pick_coord(), pick_coord(), pick_extent(), pick_extent());
         files++;
         mag = $urandom_range(5);
         h = good_header($urandom_range(6), $urandom_range(1) ? mag : -mag, 54);
         case ($urandom_range(3))
            0: h.offset = 54 + $urandom_range(12, 1);
            1: h.offset = $urandom_range(53);
            2: h.offset = 0;
            default: ;
         endcase
         pick = $urandom_range(99);
         if (pick < 8) begin
            case ($urandom_range(2))
               0: begin h.width = 32'h0000_FFFF; h.height = 0; end
               1: begin h.width = 0; h.height = 32'hFFFF_0001; end
               default: begin
                  h.width  = $urandom_range(40, 16);
                  h.height = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
               end
            endcase
         end
         if (pick >= 8 && pick < 25) begin
            h = break_header(h);
            body = $urandom_range(3);
         end else begin
            body = full_body(h);
            // some files stop short and get cut off by the next start
            if ($urandom_range(9) == 0) body = $urandom_range(body);
            else body = body + $urandom_range(3);
         end
         send_file(h, body);
      end
      steady = 1'b0;
   endtask

   // result side: random ready, long hold-off on request, in-order compare
   always @(posedge clock) begin : result_check
      decoded_type want;
      if (rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result of kind %0d", rsp_kind));
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_error_code !== want.code)
               report_mismatch($sformatf("error_code %0d, want %0d", rsp_error_code, want.code));
            if (rsp_px_x !== want.x)
               report_mismatch($sformatf("px_x %0d, want %0d", rsp_px_x, want.x));
            if (rsp_px_y !== want.y)
               report_mismatch($sformatf("px_y %0d, want %0d", rsp_px_y, want.y));
            if (rsp_red !== want.red)
               report_mismatch($sformatf("red %0h, want %0h", rsp_red, want.red));
            if (rsp_green !== want.green)
               report_mismatch($sformatf("green %0h, want %0h", rsp_green, want.green));
            if (rsp_blue !== want.blue)
               report_mismatch($sformatf("blue %0h, want %0h", rsp_blue, want.blue));
         end
      end
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // counts cycles with no beat moving on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d results pending", stall_cycles,
                  due_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) win_reg[i] = 16'h0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_ignored_before_start();
      test_plain_images();
      test_pending_done();
      test_empty_images();
      test_aborted_images();
      test_header_errors();
      test_window_clamp();
      test_backpressure();
      test_random_files();
      drain();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
